// ===== hw/rtl/jlss_pkg.sv =====
// jlss_pkg: shared constants, select codes and the controller/datapath
// command and status structs of the junction lane service scheduler
// no dependencies
package jlss_pkg;

  // default sizing
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ROAD_COUNT_DEF  = 4;

  // fixed shape of the junction
  localparam int LANES_PER_ROAD = 3;
  localparam int PRIO_LANE      = 1;
  localparam int ID_W           = 16;
  localparam int ROAD_W         = 2;
  localparam int LANE_W         = 2;
  localparam int THR_W          = 5;
  localparam int THR_RESET      = 5;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // register index of the threshold register
  localparam logic REG_THRESHOLD = 1'b0;

  // lane index select codes for the datapath read port
  localparam logic [1:0] SEL_ARR   = 2'd0;
  localparam logic [1:0] SEL_PRIO  = 2'd1;
  localparam logic [1:0] SEL_SCAN  = 2'd2;
  localparam logic [1:0] SEL_SERVE = 2'd3;

  typedef struct packed {
    logic [1:0] sel;
    logic       load;
    logic       arrive;
    logic       start_prio;
    logic       start_scan;
    logic       scan_step;
    logic       div_init;
    logic       div_step;
    logic       total_step;
    logic       green_adv;
    logic       lane_next;
    logic       lane_load;
    logic       pop_rd;
    logic       pop_emit;
    logic       empty_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic prio_hit;
    logic scan_last;
    logic div_last;
    logic lane_end;
    logic n_zero;
    logic fill_zero;
    logic k_zero;
    logic last_pop;
  } sts_t;

endpackage

// ===== hw/rtl/jlss_ram.sv =====
// jlss_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module jlss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/jlss_ctrl.sv =====
// jlss_ctrl: sequencing state machine for arrivals and serves
// depends on jlss_pkg (cmd_t, sts_t, select codes)
module jlss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_ready,
  input  jlss_pkg::sts_t sts,
  output jlss_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ARRIVE = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_DIVI   = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_TOTAL  = 4'd6;
  localparam logic [3:0] ST_LLOAD  = 4'd7;
  localparam logic [3:0] ST_POPRD  = 4'd8;
  localparam logic [3:0] ST_POPOUT = 4'd9;
  localparam logic [3:0] ST_EMPTY  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = jlss_pkg::SEL_SERVE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? ST_DECIDE : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        cmd.sel = jlss_pkg::SEL_ARR;
        if (sts.out_free) begin
          cmd.arrive = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        cmd.sel = jlss_pkg::SEL_PRIO;
        if (sts.prio_hit) begin
          cmd.start_prio = 1'b1;
          state_nxt      = ST_POPRD;
        end else begin
          cmd.start_scan = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.sel       = jlss_pkg::SEL_SCAN;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TOTAL;
        end
      end
      ST_TOTAL: begin
        cmd.total_step = 1'b1;
        if (sts.lane_end) begin
          cmd.green_adv = 1'b1;
          state_nxt     = ST_LLOAD;
        end
      end
      ST_LLOAD: begin
        if (sts.n_zero) begin
          state_nxt = ST_EMPTY;
        end else if (sts.fill_zero) begin
          cmd.lane_next = 1'b1;
        end else begin
          cmd.lane_load = 1'b1;
          state_nxt     = ST_POPRD;
        end
      end
      ST_POPRD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POPOUT;
      end
      ST_POPOUT: begin
        if (sts.out_free) begin
          cmd.pop_emit = 1'b1;
          if (sts.last_pop) begin
            state_nxt = ST_IDLE;
          end else if (sts.k_zero) begin
            cmd.lane_next = 1'b1;
            state_nxt     = ST_LLOAD;
          end else begin
            state_nxt = ST_POPRD;
          end
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/jlss_dp.sv =====
// jlss_dp: lane queues, occupancy scan, average divider and result register
// depends on jlss_pkg and jlss_ram
module jlss_dp #(
  parameter int QUEUE_DEPTH = jlss_pkg::QUEUE_DEPTH_DEF,
  parameter int ROAD_COUNT  = jlss_pkg::ROAD_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  jlss_pkg::cmd_t                  cmd,
  output jlss_pkg::sts_t                  sts,
  input  logic [jlss_pkg::THR_W-1:0]      thr,
  input  logic [jlss_pkg::ROAD_W-1:0]     in_road,
  input  logic [jlss_pkg::LANE_W-1:0]     in_lane,
  input  logic [jlss_pkg::ID_W-1:0]       in_vehicle_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_vehicle_valid,
  output logic [jlss_pkg::ID_W-1:0]       out_released_id,
  output logic [jlss_pkg::ROAD_W-1:0]     out_from_road,
  output logic [jlss_pkg::LANE_W-1:0]     out_from_lane,
  output logic                            out_priority_mode,
  output logic                            out_dropped,
  output logic [jlss_pkg::ROAD_W-1:0]     out_green_road,
  output logic                            out_last
);

  localparam int LANE_TOTAL = ROAD_COUNT * jlss_pkg::LANES_PER_ROAD;
  localparam int LIDX_W     = $clog2(LANE_TOTAL);
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int HEAD_W     = $clog2(QUEUE_DEPTH);
  localparam int SUM_W      = $clog2((LANE_TOTAL - 1) * QUEUE_DEPTH + 1);
  localparam int CNT_W      = $clog2(LANE_TOTAL);
  localparam int DSTEP_W    = $clog2(SUM_W);
  localparam int NTOT_W     = $clog2(jlss_pkg::LANES_PER_ROAD * QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH  = LANE_TOTAL * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  // per lane queue pointers
  logic [FILL_W-1:0] fill_r [LANE_TOTAL];
  logic [HEAD_W-1:0] head_r [LANE_TOTAL];

  // latched input item
  logic [jlss_pkg::ROAD_W-1:0] road_in_r;
  logic [jlss_pkg::LANE_W-1:0] lane_in_r;
  logic [jlss_pkg::ID_W-1:0]   id_in_r;

  // serve state
  logic [jlss_pkg::ROAD_W-1:0] green_r;
  logic [jlss_pkg::ROAD_W-1:0] road_r;
  logic [jlss_pkg::LANE_W-1:0] lane_r;
  logic                        prio_r;
  logic [LIDX_W-1:0]           scan_r;
  logic [SUM_W-1:0]            sum_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [SUM_W-1:0]            quot_r;
  logic [CNT_W-1:0]            rem_r;
  logic [DSTEP_W-1:0]          dstep_r;
  logic [NTOT_W-1:0]           ntot_r;
  logic [NTOT_W-1:0]           rel_r;
  logic [FILL_W-1:0]           k_r;

  // popped id capture
  logic                        pop_rd_r;
  logic [jlss_pkg::ID_W-1:0]   pop_id_r;
  logic [jlss_pkg::ID_W-1:0]   pop_id;

  // result register
  logic                        ov_r;
  logic                        o_vv_r;
  logic [jlss_pkg::ID_W-1:0]   o_id_r;
  logic [jlss_pkg::ROAD_W-1:0] o_road_r;
  logic [jlss_pkg::LANE_W-1:0] o_lane_r;
  logic                        o_prio_r;
  logic                        o_drop_r;
  logic [jlss_pkg::ROAD_W-1:0] o_green_r;
  logic                        o_last_r;

  logic                   arr_ok_idx;
  logic [LIDX_W-1:0]      arr_idx;
  logic [LIDX_W-1:0]      serve_idx;
  logic [LIDX_W-1:0]      rd_idx;
  logic [FILL_W-1:0]      fill_sel;
  logic [HEAD_W-1:0]      head_sel;
  logic                   arr_ok;
  logic [FILL_W:0]        pos_sum;
  logic [HEAD_W-1:0]      pos;
  logic [HEAD_W-1:0]      head_inc;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [jlss_pkg::ID_W-1:0] rdata;
  logic [FILL_W-1:0]      avg;
  logic [FILL_W-1:0]      kmin;
  logic [CNT_W:0]         rem_sh;
  logic                   q_bit;
  logic [jlss_pkg::ROAD_W-1:0] green_inc;
  logic [jlss_pkg::THR_W-1:0]  prio_cnt;

  // lane index decode
  assign arr_ok_idx = ({1'b0, road_in_r} < 3'(ROAD_COUNT)) &&
                      (lane_in_r < jlss_pkg::LANE_W'(jlss_pkg::LANES_PER_ROAD));
  assign arr_idx    = arr_ok_idx
                    ? LIDX_W'(road_in_r * jlss_pkg::LANES_PER_ROAD + lane_in_r)
                    : '0;
  assign serve_idx  = LIDX_W'(road_r * jlss_pkg::LANES_PER_ROAD + lane_r);

  always_comb begin
    case (cmd.sel)
      jlss_pkg::SEL_ARR:  rd_idx = arr_idx;
      jlss_pkg::SEL_PRIO: rd_idx = LIDX_W'(jlss_pkg::PRIO_LANE);
      jlss_pkg::SEL_SCAN: rd_idx = scan_r;
      default:            rd_idx = serve_idx;
    endcase
  end

  assign fill_sel = fill_r[rd_idx];
  assign head_sel = head_r[rd_idx];

  // arrival tail position
  assign arr_ok  = arr_ok_idx && (fill_sel < FILL_W'(QUEUE_DEPTH));
  assign pos_sum = {1'b0, FILL_W'(head_sel)} + {1'b0, fill_sel};
  assign pos     = (pos_sum >= (FILL_W + 1)'(QUEUE_DEPTH))
                 ? HEAD_W'(pos_sum - (FILL_W + 1)'(QUEUE_DEPTH))
                 : HEAD_W'(pos_sum);
  assign head_inc = (head_sel == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
  assign waddr    = ADDR_W'(rd_idx * QUEUE_DEPTH) + ADDR_W'(pos);
  assign raddr    = ADDR_W'(rd_idx * QUEUE_DEPTH) + ADDR_W'(head_sel);

  jlss_ram #(
    .WIDTH(jlss_pkg::ID_W),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.arrive && arr_ok),
    .waddr(waddr),
    .wdata(id_in_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // ram data is good only right after the pop read, keep it while the output waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_rd_r <= 1'b0;
    end else begin
      pop_rd_r <= cmd.pop_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_rd_r) begin
      pop_id_r <= rdata;
    end
  end

  assign pop_id = pop_rd_r ? rdata : pop_id_r;

  // average, release count and divider step
  assign avg      = (cnt_r == '0) ? FILL_W'(1) : FILL_W'(quot_r);
  assign kmin     = (fill_sel < avg) ? fill_sel : avg;
  assign rem_sh   = {rem_r, quot_r[SUM_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, cnt_r});
  assign green_inc = ({1'b0, green_r} == 3'(ROAD_COUNT - 1)) ? '0 : green_r + 1'b1;
  assign prio_cnt = jlss_pkg::THR_W'(fill_sel) - thr;

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_TOTAL; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else if (cmd.arrive && arr_ok) begin
      fill_r[rd_idx] <= fill_sel + 1'b1;
    end else if (cmd.pop_rd) begin
      fill_r[rd_idx] <= fill_sel - 1'b1;
      head_r[rd_idx] <= head_inc;
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      road_in_r <= in_road;
      lane_in_r <= in_lane;
      id_in_r   <= in_vehicle_id;
    end
  end

  // green pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_r <= '0;
    end else if (cmd.start_prio || cmd.green_adv) begin
      green_r <= green_inc;
    end
  end

  // serve sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.start_prio) begin
      prio_r <= 1'b1;
      road_r <= '0;
      lane_r <= jlss_pkg::LANE_W'(jlss_pkg::PRIO_LANE);
      k_r    <= FILL_W'(prio_cnt);
      ntot_r <= NTOT_W'(prio_cnt);
      rel_r  <= '0;
    end
    if (cmd.start_scan) begin
      prio_r <= 1'b0;
      road_r <= green_r;
      lane_r <= '0;
      scan_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      ntot_r <= '0;
      rel_r  <= '0;
    end
    if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
      if ((scan_r != LIDX_W'(jlss_pkg::PRIO_LANE)) && (fill_sel != '0)) begin
        sum_r <= sum_r + SUM_W'(fill_sel);
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.div_init) begin
      quot_r  <= sum_r;
      rem_r   <= '0;
      dstep_r <= '0;
    end
    if (cmd.div_step) begin
      quot_r  <= {quot_r[SUM_W-2:0], q_bit};
      rem_r   <= q_bit ? CNT_W'(rem_sh - {1'b0, cnt_r}) : CNT_W'(rem_sh);
      dstep_r <= dstep_r + 1'b1;
    end
    if (cmd.total_step) begin
      ntot_r <= ntot_r + NTOT_W'(kmin);
      lane_r <= sts.lane_end ? '0 : lane_r + 1'b1;
    end
    if (cmd.lane_next) begin
      lane_r <= lane_r + 1'b1;
    end
    if (cmd.lane_load) begin
      k_r <= kmin;
    end
    if (cmd.pop_rd) begin
      k_r <= k_r - 1'b1;
    end
    if (cmd.pop_emit) begin
      rel_r <= rel_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.arrive || cmd.pop_emit || cmd.empty_emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arrive || cmd.empty_emit) begin
      o_vv_r    <= 1'b0;
      o_id_r    <= '0;
      o_road_r  <= '0;
      o_lane_r  <= '0;
      o_prio_r  <= cmd.empty_emit && prio_r;
      o_drop_r  <= cmd.arrive && !arr_ok;
      o_green_r <= green_r;
      o_last_r  <= 1'b1;
    end else if (cmd.pop_emit) begin
      o_vv_r    <= 1'b1;
      o_id_r    <= pop_id;
      o_road_r  <= road_r;
      o_lane_r  <= lane_r;
      o_prio_r  <= prio_r;
      o_drop_r  <= 1'b0;
      o_green_r <= green_r;
      o_last_r  <= sts.last_pop;
    end
  end

  // status toward the controller
  always_comb begin
    sts.out_free  = !ov_r || out_ready;
    sts.prio_hit  = jlss_pkg::THR_W'(fill_sel) > thr;
    sts.scan_last = (scan_r == LIDX_W'(LANE_TOTAL - 1));
    sts.div_last  = (dstep_r == DSTEP_W'(SUM_W - 1));
    sts.lane_end  = (lane_r == jlss_pkg::LANE_W'(jlss_pkg::LANES_PER_ROAD - 1));
    sts.n_zero    = (ntot_r == '0);
    sts.fill_zero = (fill_sel == '0);
    sts.k_zero    = (k_r == '0);
    sts.last_pop  = ((rel_r + 1'b1) == ntot_r);
  end

  assign out_valid         = ov_r;
  assign out_vehicle_valid = o_vv_r;
  assign out_released_id   = o_id_r;
  assign out_from_road     = o_road_r;
  assign out_from_lane     = o_lane_r;
  assign out_priority_mode = o_prio_r;
  assign out_dropped       = o_drop_r;
  assign out_green_road    = o_green_r;
  assign out_last          = o_last_r;

endmodule

// ===== hw/rtl/junction_lane_service_scheduler.sv =====
// arrival: latch on accept, then enqueue and result once the output is free
// serve, priority: decide, then a pop read and a result per released vehicle
// serve, normal: decide, occupancy scan over every lane, divider init and steps,
//   release total over the green road lanes, then lane loads and vehicle pops
// one item at a time; results wait in an output register
// reset (synchronous, rst_n low): lanes empty, road A green, threshold 5
module junction_lane_service_scheduler #(
  parameter int QUEUE_DEPTH = jlss_pkg::QUEUE_DEPTH_DEF,
  parameter int ROAD_COUNT  = jlss_pkg::ROAD_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic [jlss_pkg::ROAD_W-1:0]        in_road,
  input  logic [jlss_pkg::LANE_W-1:0]        in_lane,
  input  logic [jlss_pkg::ID_W-1:0]          in_vehicle_id,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_vehicle_valid,
  output logic [jlss_pkg::ID_W-1:0]          out_released_id,
  output logic [jlss_pkg::ROAD_W-1:0]        out_from_road,
  output logic [jlss_pkg::LANE_W-1:0]        out_from_lane,
  output logic                               out_priority_mode,
  output logic                               out_dropped,
  output logic [jlss_pkg::ROAD_W-1:0]        out_green_road,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jlss_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [jlss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [jlss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [jlss_pkg::THR_W-1:0] thr_r;
  jlss_pkg::cmd_t cmd;
  jlss_pkg::sts_t sts;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= jlss_pkg::THR_W'(jlss_pkg::THR_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == jlss_pkg::REG_THRESHOLD)) begin
      thr_r <= pwdata[jlss_pkg::THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == jlss_pkg::REG_THRESHOLD)
                ? jlss_pkg::APB_DATA_W'(thr_r) : '0;

  jlss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_mode (in_mode),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  jlss_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ROAD_COUNT (ROAD_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .thr              (thr_r),
    .in_road          (in_road),
    .in_lane          (in_lane),
    .in_vehicle_id    (in_vehicle_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vehicle_valid(out_vehicle_valid),
    .out_released_id  (out_released_id),
    .out_from_road    (out_from_road),
    .out_from_lane    (out_from_lane),
    .out_priority_mode(out_priority_mode),
    .out_dropped      (out_dropped),
    .out_green_road   (out_green_road),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a refused arrival releases nothing and ends its item
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_vehicle_valid && out_last)
    else $error("drop result malformed");

  // priority releases come only from road A lane index 1 (PRIO_LANE)
  a_prio_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_priority_mode && out_vehicle_valid |->
      out_from_road == '0 && out_from_lane == jlss_pkg::LANE_W'(jlss_pkg::PRIO_LANE))
    else $error("priority release from wrong lane");
`endif

endmodule

// ===== tb/tb_junction_lane_service_scheduler.sv =====
// tb_junction_lane_service_scheduler: self-checking bench for the junction lane scheduler
// drives arrivals and serves, predicts released vehicles from its own lane model
// depends on jlss_pkg and junction_lane_service_scheduler
module tb_junction_lane_service_scheduler;

  localparam int QDEPTH = jlss_pkg::QUEUE_DEPTH_DEF;
  localparam int NROADS = jlss_pkg::ROAD_COUNT_DEF;
  localparam int LPR    = jlss_pkg::LANES_PER_ROAD;
  localparam int NLANES = NROADS * LPR;
  localparam int PRIO   = jlss_pkg::PRIO_LANE;
  localparam int ID_W   = jlss_pkg::ID_W;
  localparam int ROAD_W = jlss_pkg::ROAD_W;
  localparam int LANE_W = jlss_pkg::LANE_W;
  localparam int THR_W  = jlss_pkg::THR_W;
  localparam int ADDR_W = jlss_pkg::APB_ADDR_W;
  localparam int DATA_W = jlss_pkg::APB_DATA_W;
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_SERVE  = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic              vehicle_valid;
    logic [ID_W-1:0]   released_id;
    logic [ROAD_W-1:0] from_road;
    logic [LANE_W-1:0] from_lane;
    logic              priority_mode;
    logic              dropped;
    logic [ROAD_W-1:0] green_road;
    logic              last;
  } release_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_mode;
  logic [ROAD_W-1:0] in_road;
  logic [LANE_W-1:0] in_lane;
  logic [ID_W-1:0] in_vehicle_id;
  logic out_valid, out_ready;
  logic out_vehicle_valid, out_priority_mode, out_dropped, out_last;
  logic [ID_W-1:0] out_released_id;
  logic [ROAD_W-1:0] out_from_road, out_green_road;
  logic [LANE_W-1:0] out_from_lane;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  junction_lane_service_scheduler dut (.*);

  // lane model
  logic [ID_W-1:0] lane_ids [NLANES][$];
  logic [1:0] green_now;
  logic [THR_W-1:0] thr_now;
  release_t pending_releases [$];

  int errors;
  int cycles;
  int send_idle_pct, recv_idle_pct;
  int hold_off;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // compute expected releases for one transaction
  function automatic void predict_item(logic mode, logic [1:0] road, logic [1:0] lane,
                                       logic [15:0] vid);
    release_t r;
    release_t rel [$];
    int idx, total, count, avg, k;
    logic prio;
    r = '0;
    prio = 1'b0;
    if (mode == MODE_ARRIVE) begin
      r.dropped = 1'b1;
      if (road < NROADS && lane < LPR) begin
        idx = road * LPR + lane;
        if (lane_ids[idx].size() < QDEPTH) begin
          lane_ids[idx] = {lane_ids[idx], vid};
          r.dropped = 1'b0;
        end
      end
      r.green_road = green_now;
      r.last = 1'b1;
      pending_releases = {pending_releases, r};
      return;
    end
    if (lane_ids[PRIO].size() > thr_now) begin
      prio = 1'b1;
      while (lane_ids[PRIO].size() > thr_now) begin
        r = '0;
        r.vehicle_valid = 1'b1;
        r.released_id = lane_ids[PRIO].pop_front();
        r.from_lane = LANE_W'(PRIO);
        rel = {rel, r};
      end
    end else begin
      total = 0;
      count = 0;
      avg = 1;
      for (int i = 0; i < NLANES; i++)
        if (i != PRIO && lane_ids[i].size() != 0) begin
          total += lane_ids[i].size();
          count++;
        end
      if (count != 0) avg = (total / count < 1) ? 1 : total / count;
      for (int l = 0; l < LPR; l++) begin
        idx = green_now * LPR + l;
        k = 0;
        while (k < avg && lane_ids[idx].size() != 0) begin
          r = '0;
          r.vehicle_valid = 1'b1;
          r.released_id = lane_ids[idx].pop_front();
          r.from_road = green_now;
          r.from_lane = LANE_W'(l);
          rel = {rel, r};
          k++;
        end
      end
    end
    green_now = 2'((green_now + 1) % NROADS);
    if (rel.size() == 0) begin
      r = '0;
      rel = {rel, r};
    end
    foreach (rel[i]) begin
      rel[i].priority_mode = prio;
      rel[i].green_road = green_now;
      rel[i].last = (i == rel.size() - 1);
      pending_releases = {pending_releases, rel[i]};
    end
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted result transaction
  always @(posedge clk) begin
    release_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_releases.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = pending_releases.pop_front();
        if (out_vehicle_valid !== exp_r.vehicle_valid) begin
          $error("vehicle_valid exp %0d got %0d", exp_r.vehicle_valid, out_vehicle_valid);
          errors++;
        end
        if (out_released_id !== exp_r.released_id) begin
          $error("released_id exp %0d got %0d", exp_r.released_id, out_released_id);
          errors++;
        end
        if (out_from_road !== exp_r.from_road) begin
          $error("from_road exp %0d got %0d", exp_r.from_road, out_from_road);
          errors++;
        end
        if (out_from_lane !== exp_r.from_lane) begin
          $error("from_lane exp %0d got %0d", exp_r.from_lane, out_from_lane);
          errors++;
        end
        if (out_priority_mode !== exp_r.priority_mode) begin
          $error("priority_mode exp %0d got %0d", exp_r.priority_mode, out_priority_mode);
          errors++;
        end
        if (out_dropped !== exp_r.dropped) begin
          $error("dropped exp %0d got %0d", exp_r.dropped, out_dropped);
          errors++;
        end
        if (out_green_road !== exp_r.green_road) begin
          $error("green_road exp %0d got %0d", exp_r.green_road, out_green_road);
          errors++;
        end
        if (out_last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, out_last);
          errors++;
        end
      end
    end
  end

  // offer one transaction, holding it until accepted
  task automatic send_item(logic mode, logic [1:0] road, logic [1:0] lane, logic [15:0] vid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_road <= road;
    in_lane <= lane;
    in_vehicle_id <= vid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(mode, road, lane, vid);
  endtask

  task automatic arrive(int road, int lane);
    send_item(MODE_ARRIVE, 2'(road), 2'(lane), 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic serve();
    send_item(MODE_SERVE, 2'($urandom_range(3)), 2'($urandom_range(3)),
              16'($urandom_range(16'hFFFF)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // apb register write, only while idle
  task automatic write_threshold(logic [THR_W-1:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * jlss_pkg::REG_THRESHOLD);
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thr_now = value;
  endtask

  // field extremes, full lane, invalid lane, empty serve
  task automatic test_directed();
    serve();
    send_item(MODE_ARRIVE, 2'd3, 2'd3, 16'hFFFF);
    send_item(MODE_ARRIVE, 2'd0, 2'd3, 16'h0000);
    for (int i = 0; i < 17; i++) send_item(MODE_ARRIVE, 2'd3, 2'd2, 16'(16'hFFFF - i));
    arrive(0, 0);
    arrive(1, 0);
    repeat (3) serve();
  endtask

  // priority lane draining at several thresholds
  task automatic test_priority(logic [THR_W-1:0] value);
    write_threshold(value);
    for (int i = 0; i < 18; i++) arrive(0, PRIO);
    serve();
    serve();
  endtask

  // random traffic, mostly valid arrivals with serves mixed in
  task automatic test_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) arrive($urandom_range(3), $urandom_range(2));
      else if (pick < 65)
        send_item(MODE_ARRIVE, 2'($urandom_range(3)), 2'($urandom_range(3)),
                  16'($urandom_range(16'hFFFF)));
      else serve();
    end
  endtask

  // long receiver stall while arrivals and serves pile up
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 30; i++) arrive($urandom_range(3), $urandom_range(2));
    repeat (4) serve();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    green_now = 2'd0;
    thr_now = THR_W'(jlss_pkg::THR_RESET);
    send_idle_pct = 35;
    recv_idle_pct = 61;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_road = '0;
    in_lane = '0;
    in_vehicle_id = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_priority(5'd0);
    test_priority(5'd16);
    test_priority(5'd31);
    write_threshold(5'd3);
    test_random(130);
    send_idle_pct = 61;
    recv_idle_pct = 35;
    test_backpressure();
    write_threshold(5'd8);
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(126);
    drain_results();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== junction_lane_service_scheduler.f =====
hw/rtl/jlss_pkg.sv
hw/rtl/jlss_ram.sv
hw/rtl/jlss_ctrl.sv
hw/rtl/jlss_dp.sv
hw/rtl/junction_lane_service_scheduler.sv
tb/tb_junction_lane_service_scheduler.sv
